[design/fah_pkg.sv]
// Shared types and constants for the first-fit heap allocator.
// Depends on nothing; every other design file imports it.
package fah_pkg;

  localparam int REQ_W  = 16;
  localparam int ADDR_W = 16;
  localparam int TOP_W  = 17;
  localparam int STAT_W = 3;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_REUSED   = 3'd0,
    ST_APPENDED = 3'd1,
    ST_MARKED   = 3'd2,
    ST_RELEASED = 3'd3,
    ST_REJECTED = 3'd4,
    ST_UNKNOWN  = 3'd5
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    WR_APPEND,
    WR_BUSY,
    WR_FREE
  } wr_kind_t;

  // Search token that walks down the cell chain.
  typedef struct packed {
    logic act;
    logic found;
  } hop_t;

  // Entry update broadcast from the controller to all cells.
  typedef struct packed {
    logic     en;
    wr_kind_t kind;
  } wr_t;

endpackage

[design/fah_req_if.sv]
// Request channel of the allocator: valid/ready plus the request payload.
// Depends on fah_pkg for field widths.
interface fah_req_if import fah_pkg::*;;
  logic              valid;
  logic              ready;
  logic              func;
  logic [REQ_W-1:0]  req_size;
  logic [ADDR_W-1:0] block_addr;

  modport source (output valid, func, req_size, block_addr, input ready);
  modport sink   (input valid, func, req_size, block_addr, output ready);
endinterface

[design/fah_rsp_if.sv]
// Result channel of the allocator: valid/ready plus the result payload.
// Depends on fah_pkg for field widths.
interface fah_rsp_if import fah_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] payload_addr;
  logic [STAT_W-1:0] status;
  logic [TOP_W-1:0]  heap_top;

  modport source (output valid, payload_addr, status, heap_top, input ready);
  modport sink   (input valid, payload_addr, status, heap_top, output ready);
endinterface

[design/first_fit_heap_allocator.sv]
// First-fit heap allocator. An accepted request is first captured in the
// controller before the search token is launched; the token then walks the
// row of table cells, registered at each cell, and the decision and the
// result register are written when the token comes back. One request is in
// flight at a time and the next is taken the cycle after the result is
// delivered, so any wait on the result side delays it. An allocate request
// reuses the earliest free block whose size is at least the request, whole,
// or appends a block of HEADER_BYTES plus the request at the heap break; a
// zero-size request, or one that neither fits nor can be appended, is
// rejected. A free request looks its block up by payload address: the tail
// block is dropped and the break shrinks, any other block is marked free,
// and an address that matches no block is reported as unknown.
// Depends on fah_pkg, fah_req_if, fah_rsp_if, fah_cell and fah_ctrl.
module first_fit_heap_allocator import fah_pkg::*; #(
  parameter int MAX_ENTRIES  = 64,
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 16
) (
  input logic   clk,
  input logic   rst_n,
  fah_req_if.sink   in_req,
  fah_rsp_if.source out_rsp
);

  // Table index, table count and heap break widths.
  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = $clog2(HEAP_BYTES + 1);

  logic              func;
  logic [REQ_W-1:0]  req_size;
  logic [ADDR_W-1:0] block_addr;
  logic [CW-1:0]     count;
  wr_t               wr;
  logic [IW-1:0]     wr_idx;
  logic [AW-1:0]     wr_start;
  logic [REQ_W-1:0]  wr_bytes;

  // Search chain: link k feeds cell k; the last link returns to the controller.
  hop_t              hop   [MAX_ENTRIES+1];
  logic [IW-1:0]     idx   [MAX_ENTRIES+1];
  logic [AW-1:0]     start [MAX_ENTRIES+1];
  logic [REQ_W-1:0]  bytes [MAX_ENTRIES+1];

  // The injected token carries no candidate yet.
  assign idx[0]   = '0;
  assign start[0] = '0;
  assign bytes[0] = '0;

  fah_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .HEAP_BYTES  (HEAP_BYTES),
    .HDR         (HEADER_BYTES),
    .IW          (IW),
    .CW          (CW),
    .AW          (AW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_req.valid),
    .in_ready         (in_req.ready),
    .in_func          (in_req.func),
    .in_req_size      (in_req.req_size),
    .in_block_addr    (in_req.block_addr),
    .out_valid        (out_rsp.valid),
    .out_ready        (out_rsp.ready),
    .out_payload_addr (out_rsp.payload_addr),
    .out_status       (out_rsp.status),
    .out_heap_top     (out_rsp.heap_top),
    .func             (func),
    .req_size         (req_size),
    .block_addr       (block_addr),
    .count            (count),
    .hop_inj          (hop[0]),
    .hop_end          (hop[MAX_ENTRIES]),
    .idx_end          (idx[MAX_ENTRIES]),
    .start_end        (start[MAX_ENTRIES]),
    .bytes_end        (bytes[MAX_ENTRIES]),
    .wr               (wr),
    .wr_idx           (wr_idx),
    .wr_start         (wr_start),
    .wr_bytes         (wr_bytes)
  );

  // One cell per table entry; the token passes the earliest hit along.
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    fah_cell #(
      .IDX (k),
      .IW  (IW),
      .CW  (CW),
      .AW  (AW),
      .HDR (HEADER_BYTES)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .count      (count),
      .func       (func),
      .req_size   (req_size),
      .block_addr (block_addr),
      .hop_i      (hop[k]),
      .idx_i      (idx[k]),
      .start_i    (start[k]),
      .bytes_i    (bytes[k]),
      .hop_o      (hop[k+1]),
      .idx_o      (idx[k+1]),
      .start_o    (start[k+1]),
      .bytes_o    (bytes[k+1]),
      .wr         (wr),
      .wr_idx     (wr_idx),
      .wr_start   (wr_start),
      .wr_bytes   (wr_bytes)
    );
  end

endmodule

[design/fah_cell.sv]
// One block-table entry of the allocator plus one stage of the search chain.
// Depends on fah_pkg.
module fah_cell import fah_pkg::*; #(
  parameter int IDX = 0,
  parameter int IW  = 6,
  parameter int CW  = 7,
  parameter int AW  = 17,
  parameter int HDR = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CW-1:0]     count,
  input  logic              func,
  input  logic [REQ_W-1:0]  req_size,
  input  logic [ADDR_W-1:0] block_addr,
  input  hop_t              hop_i,
  input  logic [IW-1:0]     idx_i,
  input  logic [AW-1:0]     start_i,
  input  logic [REQ_W-1:0]  bytes_i,
  output hop_t              hop_o,
  output logic [IW-1:0]     idx_o,
  output logic [AW-1:0]     start_o,
  output logic [REQ_W-1:0]  bytes_o,
  input  wr_t               wr,
  input  logic [IW-1:0]     wr_idx,
  input  logic [AW-1:0]     wr_start,
  input  logic [REQ_W-1:0]  wr_bytes
);

  logic [AW-1:0]    start_r;
  logic [REQ_W-1:0] bytes_r;
  logic             free_r;
  hop_t             hop_r;
  logic [IW-1:0]    idx_r;
  logic [AW-1:0]    fstart_r;
  logic [REQ_W-1:0] fbytes_r;

  logic [AW:0] pay;
  logic        live, match, hit;

  assign pay  = {1'b0, start_r} + (AW+1)'(HDR);
  assign live = CW'(IDX) < count;

  always_comb begin
    if (func == FUNC_FREE) begin
      match = (ADDR_W'(pay) == block_addr) && (32'(pay) <= 32'hFFFF);
    end else begin
      match = free_r && (bytes_r >= req_size);
    end
  end

  assign hit = hop_i.act && !hop_i.found && live && match;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr.en && wr_idx == IW'(IDX)) begin
      unique case (wr.kind)
        WR_APPEND: begin
          start_r <= wr_start;
          bytes_r <= wr_bytes;
          free_r  <= 1'b0;
        end
        WR_BUSY: free_r <= 1'b0;
        WR_FREE: free_r <= 1'b1;
        default: free_r <= free_r;
      endcase
    end
  end

  // Search stage toward the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_r <= '0;
    end else begin
      hop_r.act   <= hop_i.act;
      hop_r.found <= hop_i.found | hit;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      idx_r    <= IW'(IDX);
      fstart_r <= start_r;
      fbytes_r <= bytes_r;
    end else begin
      idx_r    <= idx_i;
      fstart_r <= start_i;
      fbytes_r <= bytes_i;
    end
  end

  assign hop_o   = hop_r;
  assign idx_o   = idx_r;
  assign start_o = fstart_r;
  assign bytes_o = fbytes_r;

endmodule

[design/fah_ctrl.sv]
// Controller of the allocator: request capture, table count, heap break,
// decision after the chain search and the result register. Depends on fah_pkg.
module fah_ctrl import fah_pkg::*; #(
  parameter int MAX_ENTRIES  = 64,
  parameter int HEAP_BYTES   = 65536,
  parameter int HDR          = 16,
  parameter int IW           = 6,
  parameter int CW           = 7,
  parameter int AW           = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [REQ_W-1:0]  in_req_size,
  input  logic [ADDR_W-1:0] in_block_addr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] out_payload_addr,
  output logic [STAT_W-1:0] out_status,
  output logic [TOP_W-1:0]  out_heap_top,
  output logic              func,
  output logic [REQ_W-1:0]  req_size,
  output logic [ADDR_W-1:0] block_addr,
  output logic [CW-1:0]     count,
  output hop_t              hop_inj,
  input  hop_t              hop_end,
  input  logic [IW-1:0]     idx_end,
  input  logic [AW-1:0]     start_end,
  input  logic [REQ_W-1:0]  bytes_end,
  output wr_t               wr,
  output logic [IW-1:0]     wr_idx,
  output logic [AW-1:0]     wr_start,
  output logic [REQ_W-1:0]  wr_bytes
);

  // The append sum must hold both a full break and a full request.
  localparam int NW = ((AW > REQ_W) ? AW : REQ_W) + 1;

  state_t            state_r, state_nxt;
  logic              func_r;
  logic [REQ_W-1:0]  req_r;
  logic [ADDR_W-1:0] addr_r;
  logic              inj_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     brk_r, brk_nxt;
  logic [ADDR_W-1:0] oaddr_r, oaddr_nxt;
  stat_t             ostat_r, ostat_nxt;
  logic [NW-1:0]     need;
  logic [AW:0]       fpay;
  logic              done, tail, full;

  assign need = NW'(brk_r) + NW'(HDR) + NW'(req_r);
  assign fpay = {1'b0, start_end} + (AW+1)'(HDR);
  assign done = (state_r == S_SCAN) && hop_end.act;
  assign tail = (CW'(idx_end) == count_r - CW'(1));
  assign full = count_r >= CW'(MAX_ENTRIES);

  // The token enters the chain in the cycle after acceptance, once the request
  // fields seen by the cells have been captured.
  assign hop_inj = '{act: inj_r, found: 1'b0};

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    brk_nxt   = brk_r;
    oaddr_nxt = oaddr_r;
    ostat_nxt = ostat_r;
    wr        = '{en: 1'b0, kind: WR_BUSY};
    wr_idx    = idx_end;
    wr_start  = brk_r;
    wr_bytes  = req_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (done) begin
          state_nxt = S_RESP;
          oaddr_nxt = '0;
          if (func_r == FUNC_ALLOC) begin
            if (req_r == '0) begin
              ostat_nxt = ST_REJECTED;
            end else if (hop_end.found) begin
              wr        = '{en: 1'b1, kind: WR_BUSY};
              oaddr_nxt = ADDR_W'(fpay);
              ostat_nxt = ST_REUSED;
            end else if (full || need > NW'(HEAP_BYTES)) begin
              ostat_nxt = ST_REJECTED;
            end else begin
              wr        = '{en: 1'b1, kind: WR_APPEND};
              wr_idx    = IW'(count_r);
              oaddr_nxt = ADDR_W'({1'b0, brk_r} + (AW+1)'(HDR));
              ostat_nxt = ST_APPENDED;
              count_nxt = count_r + CW'(1);
              brk_nxt   = AW'(need);
            end
          end else if (hop_end.found) begin
            if (tail) begin
              brk_nxt   = brk_r - AW'(HDR) - AW'(bytes_end);
              count_nxt = count_r - CW'(1);
              ostat_nxt = ST_RELEASED;
            end else begin
              wr        = '{en: 1'b1, kind: WR_FREE};
              ostat_nxt = ST_MARKED;
            end
          end else begin
            ostat_nxt = ST_UNKNOWN;
          end
        end
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      brk_r   <= '0;
      inj_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      brk_r   <= brk_nxt;
      inj_r   <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    oaddr_r <= oaddr_nxt;
    ostat_r <= ostat_nxt;
    if (in_valid && in_ready) begin
      func_r <= in_func;
      req_r  <= in_req_size;
      addr_r <= in_block_addr;
    end
  end

  assign out_payload_addr = oaddr_r;
  assign out_status       = ostat_r;
  assign out_heap_top     = TOP_W'(brk_r);
  assign func             = func_r;
  assign req_size         = req_r;
  assign block_addr       = addr_r;
  assign count            = count_r;

endmodule

[design/fah_checker.sv]
// Port-level checks for the allocator, bound to the top level.
// Depends on fah_pkg and first_fit_heap_allocator.
module fah_checker import fah_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] payload_addr,
  input logic [STAT_W-1:0] status,
  input logic [TOP_W-1:0]  heap_top
);

  // Only one request is in flight, so no new request while a result waits.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while a result is pending");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status <= ST_UNKNOWN))
    else $error("result status out of range");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status != ST_REUSED && status != ST_APPENDED)
      |-> (payload_addr == '0))
    else $error("nonzero address on a result without a grant");

  // The heap break moves only while a request is being worked on.
  a_top_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && $past(in_ready) && $past(rst_n)) |-> $stable(heap_top))
    else $error("heap break changed while idle");

  // A result that is not taken stays offered and unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(payload_addr) && $stable(status) && $stable(heap_top)))
    else $error("waiting result dropped or changed");

endmodule

bind first_fit_heap_allocator fah_checker u_fah_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_req.ready),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .payload_addr (out_rsp.payload_addr),
  .status       (out_rsp.status),
  .heap_top     (out_rsp.heap_top)
);
